### design/dstm_pkg.sv
// Package for the density splat tone-map block: geometry, field widths,
// queue command and pixel-store entry types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dstm_pkg;

  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;
  localparam int PIXELS       = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = $clog2(PIXELS);

  localparam int SUM_W   = 40;
  localparam int COUNT_W = 24;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [31:0]        LOG10_2   = 32'h4D104D42;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 3'd3;

  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [1:0] {
    OP_NULL,
    OP_SPLAT,
    OP_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    addr_t       addr;
    logic [15:0] red_w;
    logic [15:0] green_w;
    logic [15:0] blue_w;
  } cmd_t;

  typedef struct packed {
    sum_t   red;
    sum_t   green;
    sum_t   blue;
    count_t count;
  } entry_t;

endpackage
`default_nettype wire

### design/dstm_if.sv
// Handshake interfaces for the request and result channels.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface dstm_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] re_coord;
  logic signed [31:0] im_coord;
  logic [15:0]        add_red;
  logic [15:0]        add_green;
  logic [15:0]        add_blue;
  logic [15:0]        pixel_index;

  modport source (output valid, kind, re_coord, im_coord, add_red, add_green,
                  add_blue, pixel_index, input ready);
  modport sink (input valid, kind, re_coord, im_coord, add_red, add_green,
                add_blue, pixel_index, output ready);
endinterface

interface dstm_rsp_if;
  logic       valid;
  logic       ready;
  logic       in_range;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, in_range, red_out, green_out, blue_out,
                  input ready);
  modport sink (input valid, in_range, red_out, green_out, blue_out,
                output ready);
endinterface
`default_nettype wire

### design/dstm_front.sv
// Front end: view registers, accepts items, maps points to pixels and
// emits one command per item. Depends on dstm_pkg and dstm_if.
`timescale 1ns / 1ps
`default_nettype none
module dstm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [dstm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dstm_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          clearing,
  dstm_req_if.sink                           req,
  output dstm_pkg::cmd_t                     cmd,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

  fstate_t     state;
  logic [31:0] x_min, y_max, x_scale, y_scale;
  logic        kind_r;
  logic [15:0] idx_r, red_r, green_r, blue_r;
  logic [32:0] dx, dy;
  logic [64:0] prod_x, prod_y;

  logic [32:0] mag_x, mag_y;
  logic [20:0] qx, qy;
  logic        ok_x, ok_y, ok_rd;
  logic [20:0] pos_x, pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min   <= 32'hE000_0000;
      y_max   <= 32'h2000_0000;
      x_scale <= 32'd4177920;
      y_scale <= 32'd4177920;
    end else if (cfg_we) begin
      case (cfg_index)
        dstm_pkg::CFG_X_MIN:   x_min   <= cfg_data;
        dstm_pkg::CFG_Y_MAX:   y_max   <= cfg_data;
        dstm_pkg::CFG_X_SCALE: x_scale <= cfg_data;
        dstm_pkg::CFG_Y_SCALE: y_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req.ready = (state == F_IDLE) && !clearing;
  assign mag_x = dx[32] ? (33'd0 - dx) : dx;
  assign mag_y = dy[32] ? (33'd0 - dy) : dy;

  always_comb begin
    qx    = prod_x[64:44];
    qy    = prod_y[64:44];
    ok_x  = dx[32] ? (qx == 21'd0) : (qx < 21'(dstm_pkg::IMAGE_WIDTH));
    ok_y  = dy[32] ? (qy == 21'd0) : (qy < 21'(dstm_pkg::IMAGE_HEIGHT));
    pos_x = dx[32] ? 21'd0 : qx;
    pos_y = dy[32] ? 21'd0 : qy;
    ok_rd = 32'(idx_r) < 32'(dstm_pkg::PIXELS);
    cmd.red_w   = red_r;
    cmd.green_w = green_r;
    cmd.blue_w  = blue_r;
    if (kind_r) begin
      cmd.op   = ok_rd ? dstm_pkg::OP_READ : dstm_pkg::OP_NULL;
      cmd.addr = dstm_pkg::ADDR_W'(idx_r);
    end else begin
      cmd.op   = (ok_x && ok_y) ? dstm_pkg::OP_SPLAT : dstm_pkg::OP_NULL;
      cmd.addr = dstm_pkg::ADDR_W'(
                   dstm_pkg::ADDR_W'(pos_y) * dstm_pkg::ADDR_W'(dstm_pkg::IMAGE_WIDTH)
                   + dstm_pkg::ADDR_W'(pos_x));
    end
  end

  assign cmd_valid = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req.valid && req.ready) begin
            kind_r  <= req.kind;
            idx_r   <= req.pixel_index;
            red_r   <= req.add_red;
            green_r <= req.add_green;
            blue_r  <= req.add_blue;
            dx <= {req.re_coord[31], req.re_coord} - {x_min[31], x_min};
            dy <= {y_max[31], y_max} - {req.im_coord[31], req.im_coord};
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod_x <= 65'(mag_x) * 65'(x_scale);
          prod_y <= 65'(mag_y) * 65'(y_scale);
          state  <= F_PUSH;
        end
        F_PUSH: begin
          if (cmd_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/dstm_queue.sv
// Two-entry command queue between front and back end.
// Depends on dstm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dstm_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  dstm_pkg::cmd_t push_cmd,
  input  wire logic      push_valid,
  output logic           push_ready,
  output dstm_pkg::cmd_t pop_cmd,
  output logic           pop_valid,
  input  wire logic      pop_ready
);

  dstm_pkg::cmd_t                 slots [dstm_pkg::QUEUE_DEPTH];
  logic [dstm_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [dstm_pkg::QPTR_W:0]      fill;
  logic                           do_push, do_pop;

  assign push_ready = fill != (dstm_pkg::QPTR_W+1)'(dstm_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

### design/dstm_back.sv
// Back end: pixel store with clearing pass, splat update, log2/log10,
// divider and tone map, result register. Depends on dstm_pkg and dstm_if.
`timescale 1ns / 1ps
`default_nettype none
module dstm_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  dstm_pkg::cmd_t cmd,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  output logic           clearing,
  dstm_rsp_if.source     rsp
);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_FETCH, B_LOG, B_L10A, B_L10B, B_DIV,
    B_TONE_MUL, B_TONE_OUT, B_EMIT
  } bstate_t;

  bstate_t             state;
  dstm_pkg::entry_t    mem [dstm_pkg::PIXELS];
  dstm_pkg::entry_t    rd_data, wr_data;
  dstm_pkg::addr_t     clr_addr, wr_addr;
  logic                wr_en, rd_en;
  dstm_pkg::cmd_t      cmd_r;

  dstm_pkg::sum_t      sum_r [3];
  dstm_pkg::count_t    c_r;
  logic [4:0]          e_r;
  logic [31:0]         m_r, frac_r;
  logic [5:0]          it_r;
  logic [63:0]         p_r;
  logic [35:0]         ek_r, div_q;
  logic [23:0]         rem_r;
  logic [1:0]          ch_r;
  logic [51:0]         hp_r, lp_r;
  logic                rng_r;
  logic [7:0]          byte_r [3];

  logic [4:0]          e_new;
  logic [63:0]         sq;
  logic [32:0]         t_sq;
  logic [24:0]         rem_sh;
  logic                q_bit;
  logic [52:0]         acc;
  logic [36:0]         v;
  logic [32:0]         vl;
  logic [40:0]         scaled;
  logic [7:0]          tone_byte;

  function automatic dstm_pkg::sum_t sat_add(dstm_pkg::sum_t a, logic [15:0] w);
    logic [dstm_pkg::SUM_W:0] s;
    s = (dstm_pkg::SUM_W+1)'(a) + (dstm_pkg::SUM_W+1)'(w);
    return s[dstm_pkg::SUM_W] ? dstm_pkg::SUM_MAX : s[dstm_pkg::SUM_W-1:0];
  endfunction

  assign clearing  = (state == B_CLEAR);
  assign cmd_ready = (state == B_IDLE);
  assign rd_en     = (state == B_IDLE) && cmd_valid;
  assign wr_en     = clearing || (state == B_FETCH && cmd_r.op == dstm_pkg::OP_SPLAT);
  assign wr_addr   = clearing ? clr_addr : cmd_r.addr;

  always_comb begin
    wr_data = '0;
    if (!clearing) begin
      wr_data.red   = sat_add(rd_data.red, cmd_r.red_w);
      wr_data.green = sat_add(rd_data.green, cmd_r.green_w);
      wr_data.blue  = sat_add(rd_data.blue, cmd_r.blue_w);
      wr_data.count = (rd_data.count == dstm_pkg::COUNT_MAX) ? rd_data.count
                                                           : rd_data.count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[cmd.addr];
  end

  // leading one of the hit count
  always_comb begin
    e_new = '0;
    for (int i = 0; i < dstm_pkg::COUNT_W; i++) begin
      if (rd_data.count[i]) e_new = 5'(i);
    end
  end

  always_comb begin
    sq     = 64'(m_r) * 64'(m_r);
    t_sq   = sq[63:31];
    rem_sh = {rem_r, div_q[35]};
    q_bit  = rem_sh >= {1'b0, c_r};
    acc    = {5'b0, hp_r[27:0], 20'b0} + {1'b0, lp_r};
    v      = acc[52:16];
    vl     = (v > 37'h1_0000_0000) ? 33'h1_0000_0000 : v[32:0];
    scaled = {vl, 8'b0} - {8'b0, vl};
    tone_byte = (hp_r >= 52'h1000_0000) ? 8'hFF : scaled[39:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // emit sets valid itself, so the drop only happens elsewhere
      if (rsp.valid && rsp.ready && state != B_EMIT) rsp.valid <= 1'b0;
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == dstm_pkg::ADDR_W'(dstm_pkg::PIXELS - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            state <= B_FETCH;
          end
        end
        B_FETCH: begin
          rng_r  <= (cmd_r.op == dstm_pkg::OP_SPLAT);
          byte_r <= '{default: 8'd0};
          state  <= B_EMIT;
          if (cmd_r.op == dstm_pkg::OP_READ && rd_data.count >= 24'd2) begin
            sum_r[0] <= rd_data.red;
            sum_r[1] <= rd_data.green;
            sum_r[2] <= rd_data.blue;
            c_r      <= rd_data.count;
            e_r      <= e_new;
            m_r      <= 32'(rd_data.count) << (5'd31 - e_new);
            frac_r   <= '0;
            it_r     <= '0;
            state    <= B_LOG;
          end
        end
        B_LOG: begin
          // one squaring per fraction bit
          if (t_sq[32]) begin
            m_r    <= t_sq[32:1];
            frac_r <= {frac_r[30:0], 1'b1};
          end else begin
            m_r    <= t_sq[31:0];
            frac_r <= {frac_r[30:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (it_r == 6'd31) state <= B_L10A;
        end
        B_L10A: begin
          p_r   <= 64'(frac_r) * 64'(dstm_pkg::LOG10_2);
          ek_r  <= 36'(e_r) * 36'(dstm_pkg::LOG10_2);
          state <= B_L10B;
        end
        B_L10B: begin
          div_q <= ek_r + 36'(p_r[63:32]);
          rem_r <= '0;
          it_r  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          // restoring divide, one quotient bit a cycle
          rem_r <= q_bit ? 24'(rem_sh - {1'b0, c_r}) : rem_sh[23:0];
          div_q <= {div_q[34:0], q_bit};
          it_r  <= it_r + 1'b1;
          if (it_r == 6'd35) begin
            ch_r  <= '0;
            state <= B_TONE_MUL;
          end
        end
        B_TONE_MUL: begin
          hp_r  <= 52'(sum_r[ch_r][39:20]) * 52'(div_q[31:0]);
          lp_r  <= 52'(sum_r[ch_r][19:0]) * 52'(div_q[31:0]);
          state <= B_TONE_OUT;
        end
        B_TONE_OUT: begin
          byte_r[ch_r] <= tone_byte;
          ch_r <= ch_r + 1'b1;
          state <= (ch_r == 2'd2) ? B_EMIT : B_TONE_MUL;
        end
        B_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.in_range  <= rng_r;
            rsp.red_out   <= byte_r[0];
            rsp.green_out <= byte_r[1];
            rsp.blue_out  <= byte_r[2];
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !rsp.valid)
    else $error("result shown during clearing pass");

  a_write_only_clear_or_splat: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == B_CLEAR || state == B_FETCH))
    else $error("store written outside clear or splat");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == B_EMIT))
    else $error("result raised outside emit");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (rem_r < c_r))
    else $error("divider remainder out of bound");

endmodule
`default_nettype wire

### design/density_splat_tone_map.sv
// Top level of the density splat tone-map block: front end, command queue
// and back end. Depends on dstm_pkg, dstm_if, dstm_front, dstm_queue, dstm_back.
//
//  channel  | dir | handshake        | contents
//  ---------+-----+------------------+------------------------------------------
//  req      | in  | valid/ready      | kind, re/im coord, rgb weights, pixel idx
//  rsp      | out | valid/ready      | in_range, red/green/blue bytes
//  cfg      | in  | cfg_we only      | cfg_index, cfg_data (x_min..y_scale)
//
// After reset the pixel store is swept to zero, one pixel a cycle, over all
// 65536 pixels at 256x256; no item is taken until that pass ends.
// Front: take, map multiply, classify into queue; a new item is taken once pushed.
// Back: a splat passes read, update-write and emit; a read of a pixel with
// two or more hits also runs the 32 log2 squarings, the 36-step divider and
// the tone map; other reads and off-image items pass read and emit, no write.
// The two-entry queue and the result register let either side stall alone.
`timescale 1ns / 1ps
`default_nettype none
module density_splat_tone_map (
  input  wire logic                           clk,
  input  wire logic                           rst,
  dstm_req_if.sink                            req,
  dstm_rsp_if.source                          rsp,
  input  wire logic                           cfg_we,
  input  wire logic [dstm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dstm_pkg::CFG_W-1:0]     cfg_data
);

  dstm_pkg::cmd_t f_cmd, b_cmd;
  logic           f_valid, f_ready, b_valid, b_ready;
  logic           clearing;

  // point mapping and item classification
  dstm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .req       (req),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  dstm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_cmd    (b_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  // store update and tone map
  dstm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (b_cmd),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .clearing  (clearing),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
